>>> rtl/sdt_pkg.sv
package sdt_pkg;

    localparam int ADDR_W    = 48;
    localparam int DBM_W     = 8;
    localparam int CHAN_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 6;
    localparam int COUNT_W   = 7;

    localparam logic FUNC_CLEAR  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd3;

    localparam logic [CHAN_W-1:0] BAND_EDGE_CHANNEL = 8'd36;

    typedef struct packed {
        logic                     band;
        logic [CHAN_W-1:0]        channel;
        logic signed [DBM_W-1:0]  strength;
        logic [ADDR_W-1:0]        address;
    } entry_t;

endpackage

>>> rtl/sdt_in_if.sv
interface sdt_in_if;

    logic                                    valid;
    logic                                    ready;
    logic                                    func;
    logic [sdt_pkg::ADDR_W-1:0]              station_address;
    logic signed [sdt_pkg::DBM_W-1:0]        signal_dbm;
    logic [sdt_pkg::CHAN_W-1:0]              radio_channel;

    modport source (
        output valid,
        input  ready,
        output func,
        output station_address,
        output signal_dbm,
        output radio_channel
    );

    modport sink (
        input  valid,
        output ready,
        input  func,
        input  station_address,
        input  signal_dbm,
        input  radio_channel
    );

endinterface

>>> rtl/sdt_out_if.sv
interface sdt_out_if;

    logic                              valid;
    logic                              ready;
    logic [sdt_pkg::STATUS_W-1:0]      status;
    logic [sdt_pkg::INDEX_W-1:0]       entry_index;
    logic [sdt_pkg::COUNT_W-1:0]       entry_count;

    modport source (
        output valid,
        input  ready,
        output status,
        output entry_index,
        output entry_count
    );

    modport sink (
        input  valid,
        output ready,
        input  status,
        input  entry_index,
        input  entry_count
    );

endinterface

>>> rtl/scan_result_dedup_table.sv
// Channel  Dir  Fields                                             Beat
// rec      in   func, station_address, signal_dbm, radio_channel   valid & ready
// res      out  status, entry_index, entry_count                   valid & ready
//
// A record beat reads and compares one stored entry per cycle through a registered
// table read, then appends the key at the fill level and loads the result; a
// duplicate stops at its match. A clear beat or a record against a full table
// goes straight from idle to loading the result.
// rst_n empties the table at once (fill count to zero); no clearing pass runs.
// rec.ready is high only while idle; a result waits in its output register
// while res.ready is low, the next beat is taken meanwhile, and its result
// holds in S_DONE until the output register drains.
module scan_result_dedup_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    sdt_in_if.sink        rec,
    sdt_out_if.source     res
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                           state_reg, state_next;
    logic [sdt_pkg::ADDR_W-1:0]           key_reg, key_next;
    logic signed [sdt_pkg::DBM_W-1:0]     dbm_reg, dbm_next;
    logic [sdt_pkg::CHAN_W-1:0]           chan_reg, chan_next;
    logic [CNT_W-1:0]                     fill_reg, fill_next;
    logic [CNT_W-1:0]                     rd_ptr_reg, rd_ptr_next;
    logic                                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                     cmp_idx_reg, cmp_idx_next;
    logic [sdt_pkg::STATUS_W-1:0]         rslt_status_reg, rslt_status_next;
    logic [IDX_W-1:0]                     rslt_index_reg, rslt_index_next;
    logic [CNT_W-1:0]                     rslt_count_reg, rslt_count_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [sdt_pkg::STATUS_W-1:0]         out_status_reg, out_status_next;
    logic [sdt_pkg::INDEX_W-1:0]          out_index_reg, out_index_next;
    logic [sdt_pkg::COUNT_W-1:0]          out_count_reg, out_count_next;

    sdt_pkg::entry_t                      table_mem [TABLE_DEPTH];
    sdt_pkg::entry_t                      rd_entry_reg;
    logic                                 mem_we;
    logic [IDX_W-1:0]                     mem_wa;
    sdt_pkg::entry_t                      mem_wd;

    logic                                 rec_beat;
    logic                                 hit;
    logic                                 table_full;
    logic [IDX_W+sdt_pkg::INDEX_W-1:0]    index_ext;
    logic [CNT_W+sdt_pkg::COUNT_W-1:0]    count_ext;

    assign rec.ready   = (state_reg == S_IDLE);
    assign rec_beat    = rec.valid && rec.ready;
    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.entry_index = out_index_reg;
    assign res.entry_count = out_count_reg;

    assign hit        = cmp_valid_reg && (rd_entry_reg.address == key_reg);
    assign table_full = (fill_reg >= CNT_W'(TABLE_DEPTH));
    assign index_ext  = {{sdt_pkg::INDEX_W{1'b0}}, rslt_index_reg};
    assign count_ext  = {{sdt_pkg::COUNT_W{1'b0}}, rslt_count_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        rd_entry_reg <= table_mem[rd_ptr_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        dbm_next         = dbm_reg;
        chan_next        = chan_reg;
        fill_next        = fill_reg;
        rd_ptr_next      = rd_ptr_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        rslt_status_next = rslt_status_reg;
        rslt_index_next  = rslt_index_reg;
        rslt_count_next  = rslt_count_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_wa           = fill_reg[IDX_W-1:0];
        mem_wd.address   = key_reg;
        mem_wd.strength  = dbm_reg;
        mem_wd.channel   = chan_reg;
        mem_wd.band      = (chan_reg >= sdt_pkg::BAND_EDGE_CHANNEL);

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (rec_beat)
                begin
                    key_next        = rec.station_address;
                    dbm_next        = rec.signal_dbm;
                    chan_next       = rec.radio_channel;
                    rslt_index_next = '0;
                    rd_ptr_next     = '0;
                    cmp_valid_next  = 1'b0;
                    priority if (rec.func == sdt_pkg::FUNC_CLEAR)
                    begin
                        fill_next        = '0;
                        rslt_status_next = sdt_pkg::ST_CLEARED;
                        rslt_count_next  = '0;
                        state_next       = S_DONE;
                    end
                    else if (table_full)
                    begin
                        rslt_status_next = sdt_pkg::ST_FULL;
                        rslt_count_next  = fill_reg;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    rslt_status_next = sdt_pkg::ST_DUPLICATE;
                    rslt_index_next  = cmp_idx_reg;
                    rslt_count_next  = fill_reg;
                    state_next       = S_DONE;
                end
                else if (rd_ptr_reg < fill_reg)
                begin
                    cmp_idx_next   = rd_ptr_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    // append at the fill level
                    mem_we           = 1'b1;
                    fill_next        = fill_reg + 1'b1;
                    rslt_status_next = sdt_pkg::ST_ADDED;
                    rslt_index_next  = fill_reg[IDX_W-1:0];
                    rslt_count_next  = fill_reg + 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rslt_status_reg;
                    out_index_next  = index_ext[sdt_pkg::INDEX_W-1:0];
                    out_count_next  = count_ext[sdt_pkg::COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        dbm_reg         <= dbm_next;
        chan_reg        <= chan_next;
        cmp_idx_reg     <= cmp_idx_next;
        rslt_status_reg <= rslt_status_next;
        rslt_index_reg  <= rslt_index_next;
        rslt_count_reg  <= rslt_count_next;
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        out_count_reg   <= out_count_next;
    end

endmodule

>>> rtl/sdt_check.sv
module sdt_check #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  logic [sdt_pkg::STATUS_W-1:0]      res_status,
    input  logic [sdt_pkg::INDEX_W-1:0]       res_entry_index,
    input  logic [sdt_pkg::COUNT_W-1:0]       res_entry_count
);

    localparam bit EXACT_COUNT = (TABLE_DEPTH < 64);
    localparam bit EXACT_INDEX = (TABLE_DEPTH <= 64);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_entry_index) && $stable(res_entry_count))
        else $error("result beat changed while stalled");

    a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == sdt_pkg::ST_CLEARED
            |-> res_entry_index == '0 && res_entry_count == '0)
        else $error("cleared beat with nonzero index or count");

    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == sdt_pkg::ST_FULL |-> res_entry_index == '0)
        else $error("full beat with nonzero index");

    a_added_last: assert property (@(posedge clk) disable iff (!rst_n)
        EXACT_INDEX && res_valid && res_status == sdt_pkg::ST_ADDED
            |-> {1'b0, res_entry_index} == res_entry_count - 7'd1)
        else $error("added index is not the last entry");

    a_dup_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        EXACT_COUNT && res_valid && res_status == sdt_pkg::ST_DUPLICATE
            |-> {1'b0, res_entry_index} < res_entry_count)
        else $error("duplicate index beyond fill level");

endmodule

bind scan_result_dedup_table sdt_check #(.TABLE_DEPTH(TABLE_DEPTH)) u_sdt_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_entry_index (res.entry_index),
    .res_entry_count (res.entry_count)
);
